[hw/rtl/bdpi_pkg.sv]
// ----------------------------------------------------------------------------
// bdpi_pkg
// Shared types and constants for the bounded deadline priority store.
// ----------------------------------------------------------------------------
package bdpi_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int FIELD_W     = 16;
   localparam int KEY_W       = 2 * FIELD_W;
   localparam int CAP_W       = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef struct packed {
      logic [FIELD_W-1:0] task_id;
      logic [FIELD_W-1:0] task_deadline;
   } req_word_type;

   typedef struct packed {
      logic               handed_back;
      logic               was_rejected;
      logic [FIELD_W-1:0] back_id;
      logic [FIELD_W-1:0] back_deadline;
      logic [4:0]         occupancy;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic update;     // take the input word and refresh the result word
   } dpath_cmd_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_HOLD = 2'b10
   } ctrl_state_type;

endpackage

[hw/rtl/bdpi_ctrl.sv]
// ----------------------------------------------------------------------------
// bdpi_ctrl
// Handshake controller: owns the result-valid state and issues updates.
// ----------------------------------------------------------------------------
module bdpi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bdpi_pkg::dpath_cmd_type cmd
);
   import bdpi_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           req_take;
   logic           rsp_take;

   // a pending result blocks new input only while it is itself stalled
   assign req_stall  = (state_ff == ST_HOLD) && rsp_stall;
   assign rsp_valid  = (state_ff == ST_HOLD);
   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign cmd.update = req_take;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_take && !req_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/bdpi_dpath.sv]
// ----------------------------------------------------------------------------
// bdpi_dpath
// Sorted slot row, capacity register and result register.
// ----------------------------------------------------------------------------
module bdpi_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  bdpi_pkg::dpath_cmd_type cmd,
   input  bdpi_pkg::req_word_type  req_word,
   input  logic                    csr_write_enable,
   input  logic [4:0]              csr_write_data,
   output bdpi_pkg::rsp_word_type  rsp_word
);
   import bdpi_pkg::*;

   logic [FIELD_W-1:0] slot_id_ff [STORE_DEPTH];
   logic [FIELD_W-1:0] slot_dl_ff [STORE_DEPTH];
   logic [FIELD_W-1:0] slot_id_in [STORE_DEPTH];
   logic [FIELD_W-1:0] slot_dl_in [STORE_DEPTH];
   logic [FIELD_W-1:0] src_id     [STORE_DEPTH];
   logic [FIELD_W-1:0] src_dl     [STORE_DEPTH];

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [CAP_W-1:0]   capacity_ff;
   rsp_word_type       rsp_word_ff;
   rsp_word_type       rsp_word_in;

   logic [KEY_W-1:0]       new_key;
   logic [KEY_W-1:0]       worst_key;
   logic [IDX_W-1:0]       worst_idx;
   logic [COUNT_W-1:0]     limit;
   logic [STORE_DEPTH-1:0] gt;
   logic [STORE_DEPTH-1:0] gt_prev;
   logic                   has_room;
   logic                   evict;
   logic                   write_slots;

   assign new_key   = {req_word.task_deadline, req_word.task_id};
   assign worst_idx = IDX_W'(count_ff - COUNT_W'(1));
   assign worst_key = {slot_dl_ff[worst_idx], slot_id_ff[worst_idx]};
   assign limit     = (COUNT_W'(capacity_ff) > COUNT_W'(STORE_DEPTH)) ?
                      COUNT_W'(STORE_DEPTH) : COUNT_W'(capacity_ff);
   assign has_room  = count_ff < limit;
   assign evict     = !has_room && (count_ff != '0) && (limit != '0) &&
                      (new_key < worst_key);
   assign write_slots = cmd.update && (has_room || evict);

   // per-slot compare; empty slots count as larger so the mask is a thermometer
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (COUNT_W'(i) < count_ff) begin
            gt[i] = {slot_dl_ff[i], slot_id_ff[i]} > new_key;
         end else begin
            gt[i] = 1'b1;
         end
      end
   end

   always_comb begin
      gt_prev[0] = 1'b0;
      src_id[0]  = req_word.task_id;
      src_dl[0]  = req_word.task_deadline;
      for (int i = 1; i < STORE_DEPTH; i++) begin
         gt_prev[i] = gt[i-1];
         src_id[i]  = slot_id_ff[i-1];
         src_dl[i]  = slot_dl_ff[i-1];
      end
   end

   // first larger slot takes the new task, slots above it shift up by one;
   // on eviction the worst entry drops off the top of the live region
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (gt[i] && !gt_prev[i]) begin
            slot_id_in[i] = req_word.task_id;
            slot_dl_in[i] = req_word.task_deadline;
         end else if (gt[i]) begin
            slot_id_in[i] = src_id[i];
            slot_dl_in[i] = src_dl[i];
         end else begin
            slot_id_in[i] = slot_id_ff[i];
            slot_dl_in[i] = slot_dl_ff[i];
         end
      end
   end

   always_comb begin
      count_in    = has_room ? count_ff + COUNT_W'(1) : count_ff;
      rsp_word_in = '0;
      rsp_word_in.handed_back  = !has_room;
      rsp_word_in.was_rejected = !has_room && !evict;
      rsp_word_in.occupancy    = 5'(count_in);
      if (evict) begin
         rsp_word_in.back_id       = slot_id_ff[worst_idx];
         rsp_word_in.back_deadline = slot_dl_ff[worst_idx];
      end else if (!has_room) begin
         rsp_word_in.back_id       = req_word.task_id;
         rsp_word_in.back_deadline = req_word.task_deadline;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         capacity_ff <= CAP_RESET;
      end else begin
         if (cmd.update) count_ff <= count_in;
         if (csr_write_enable) capacity_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (write_slots) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            slot_id_ff[i] <= slot_id_in[i];
            slot_dl_ff[i] <= slot_dl_in[i];
         end
      end
      if (cmd.update) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_word = rsp_word_ff;

endmodule

[hw/rtl/bounded_deadline_priority_insert.sv]
// ----------------------------------------------------------------------------
// bounded_deadline_priority_insert
// Keeps the smallest (deadline, id) tasks up to a programmed capacity.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one task word (id, deadline). Each accepted word
//   produces exactly one rsp_ word: whether a task is handed back, whether it
//   is the arriving task (rejected) or an evicted worst entry, its id and
//   deadline, and the occupancy after the insert.
//   csr_write_enable / csr_write_data set the capacity (1..16, larger values
//   act as 16, zero rejects everything). Write it only while the block idles.
// Timing:
//   The result is registered: the word accepted at one edge is presented on
//   rsp_ from the next cycle. Throughput is one word per cycle while req_stall
//   is low; every slot compares against the new key in the same cycle and the
//   sorted row shifts in place. While rsp_valid is high and rsp_stall is set,
//   req_stall is asserted and the pending result word holds; a result taken
//   in a cycle frees room for a new request in that same cycle.
// Reset:
//   Synchronous reset empties the store, sets capacity to 16 and drops
//   rsp_valid. Slot contents are not cleared; only live slots are ever read.
// ----------------------------------------------------------------------------
module bounded_deadline_priority_insert (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bdpi_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bdpi_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [4:0]             csr_write_data
);
   import bdpi_pkg::*;

   dpath_cmd_type cmd;

   bdpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bdpi_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_word         (req_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_word         (rsp_word)
   );

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted word produced no result");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.occupancy <= 5'(STORE_DEPTH)))
      else $error("occupancy above store depth");

   a_reject_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.was_rejected) |-> rsp_word.handed_back)
      else $error("reject without hand back");

   a_empty_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.handed_back) |->
         (rsp_word.back_id == '0 && rsp_word.back_deadline == '0))
      else $error("returned fields set with nothing handed back");

endmodule

[verif/task_store_checker.sv]
// ----------------------------------------------------------------------------
// task_store_checker
// Watches both channels and the capacity port of the priority store, keeps
// its own sorted copy of the stored task keys, predicts each result word and
// compares it field by field with what the block hands back.
// ----------------------------------------------------------------------------
module task_store_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  bdpi_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bdpi_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic [4:0]             csr_write_data,
   output int                     error_count,
   output int                     pending_count
);
   import bdpi_pkg::*;

   localparam int PRINT_LIMIT = 40;

   // sorted ascending by {deadline, id}; only entries below live_count are valid
   logic [KEY_W-1:0] slot_key [STORE_DEPTH];
   int               live_count;
   logic [CAP_W-1:0] cap_reg;
   rsp_word_type     expected_returns [$];
   int               mismatch_total;
   int               result_index;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_total < PRINT_LIMIT)
         $display("checker: result %0d: %s: got %0h, expected %0h",
                  result_index, what, got, want);
      mismatch_total++;
   endtask

   task automatic store_key(input logic [KEY_W-1:0] key);
      int pos;
      pos = live_count;
      while (pos > 0 && slot_key[pos-1] > key) begin
         slot_key[pos] = slot_key[pos-1];
         pos--;
      end
      slot_key[pos] = key;
      live_count++;
   endtask

   task automatic predict_insert(input req_word_type w, output rsp_word_type r);
      logic [KEY_W-1:0] key;
      int               limit;
      key   = {w.task_deadline, w.task_id};
      limit = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : int'(cap_reg);
      r     = '0;
      if (live_count < limit) begin
         store_key(key);
      end else if (live_count > 0 && limit > 0 && key < slot_key[live_count-1]) begin
         // full store, smaller key: worst entry goes back, occupancy unchanged
         r.handed_back   = 1'b1;
         r.back_id       = slot_key[live_count-1][FIELD_W-1:0];
         r.back_deadline = slot_key[live_count-1][KEY_W-1:FIELD_W];
         live_count--;
         store_key(key);
      end else begin
         r.handed_back   = 1'b1;
         r.was_rejected  = 1'b1;
         r.back_id       = w.task_id;
         r.back_deadline = w.task_deadline;
      end
      r.occupancy = 5'(live_count);
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         live_count = 0;
         cap_reg    = CAP_RESET;
         expected_returns.delete();
      end else begin
         if (csr_write_enable)
            cap_reg = csr_write_data;
         // a result word always belongs to an earlier request word
         if (rsp_valid && !rsp_stall) begin
            got = rsp_word;
            if (expected_returns.size() == 0) begin
               report_mismatch("result word with nothing expected",
                               {got.back_deadline, got.back_id}, '0);
            end else begin
               want = expected_returns.pop_front();
               if (got.handed_back !== want.handed_back)
                  report_mismatch("handed_back", 32'(got.handed_back),
                                  32'(want.handed_back));
               if (got.was_rejected !== want.was_rejected)
                  report_mismatch("was_rejected", 32'(got.was_rejected),
                                  32'(want.was_rejected));
               if (got.back_id !== want.back_id)
                  report_mismatch("back_id", 32'(got.back_id), 32'(want.back_id));
               if (got.back_deadline !== want.back_deadline)
                  report_mismatch("back_deadline", 32'(got.back_deadline),
                                  32'(want.back_deadline));
               if (got.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(got.occupancy),
                                  32'(want.occupancy));
            end
            result_index++;
         end
         if (req_valid && !req_stall) begin
            predict_insert(req_word, want);
            expected_returns.push_back(want);
         end
      end
      error_count   <= mismatch_total;
      pending_count <= expected_returns.size();
   end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives task words into the bounded priority store under a series of
// capacity settings, with random idling on both channels, and reports the
// verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module testbench;
   import bdpi_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   req_word_type req_word         = '0;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [4:0]   csr_write_data   = '0;

   int error_count;
   int pending_count;
   int idle_cycles;
   int tasks_sent;
   int cap_writes;
   bit steady;
   bit long_hold;

   always #5 clock = ~clock;

   bounded_deadline_priority_insert dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   task_store_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   // no word moving on either channel for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (steady) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_task(input logic [15:0] id, input logic [15:0] dl);
      if (!steady && !long_hold && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_word.task_id   <= id;
      req_word.task_deadline <= dl;
      do @(posedge clock); while (req_stall);
      tasks_sent++;
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [4:0] value);
      drain_all();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cap_writes++;
   endtask

   // mix of wide random keys, clustered keys that collide, and extremes
   task automatic pick_task(output logic [15:0] id, output logic [15:0] dl);
      case ($urandom_range(0, 9)) inside
         [0:3]: begin
            id = 16'($urandom);
            dl = 16'($urandom);
         end
         [4:6]: begin
            id = 16'($urandom_range(0, 3));
            dl = 16'($urandom_range(0, 15));
         end
         7: begin
            id = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            dl = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
         end
         8: begin
            id = 16'($urandom);
            dl = 16'($urandom_range(0, 3));
         end
         default: begin
            id = 16'($urandom);
            dl = 16'($urandom_range(16'hfff0, 16'hffff));
         end
      endcase
   endtask

   task automatic random_phase(input logic [4:0] cap, input int count, input int pause_at);
      logic [15:0] id;
      logic [15:0] dl;
      set_capacity(cap);
      for (int n = 0; n < count; n++) begin
         if (n == pause_at)
            drain_all();
         pick_task(id, dl);
         send_task(id, dl);
      end
   endtask

   initial begin
      logic [15:0] id;
      logic [15:0] dl;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: extremes of both fields, an equal key beside its twin
      send_task(16'h0000, 16'h0000);
      send_task(16'hffff, 16'hffff);
      send_task(16'hffff, 16'h0000);
      send_task(16'h0000, 16'hffff);
      send_task(16'hffff, 16'hffff);
      send_task(16'h0001, 16'h8000);
      // capacity below occupancy: an eviction, a reject, then another eviction
      set_capacity(5'd3);
      send_task(16'h0002, 16'h0000);
      send_task(16'hffff, 16'hffff);
      send_task(16'h0000, 16'h0000);
      // zero capacity rejects everything
      set_capacity(5'd0);
      send_task(16'h0000, 16'h0000);
      send_task(16'h1234, 16'h5678);
      // past the store depth
      set_capacity(5'd31);
      send_task(16'h0000, 16'h0001);
      send_task(16'hffff, 16'hfffe);
      // single entry
      set_capacity(5'd1);
      send_task(16'h0003, 16'h0003);
      send_task(16'h0000, 16'h0000);

      random_phase(5'd16, 90, -1);
      random_phase(5'd1, 90, -1);
      // long hold-off on the result side while words keep being offered
      set_capacity(5'd17);
      long_hold = 1'b1;
      for (int n = 0; n < 30; n++) begin
         pick_task(id, dl);
         send_task(id, dl);
      end
      random_phase(5'd17, 60, -1);
      random_phase(5'd0, 40, -1);
      random_phase(5'd31, 90, 45);
      random_phase(5'd2, 90, -1);
      random_phase(5'd8, 90, 30);
      random_phase(5'($urandom_range(0, 31)), 90, -1);

      // last stretch runs back to back on both sides
      steady = 1'b1;
      random_phase(5'd16, 100, -1);

      drain_all();
      repeat (5) @(posedge clock);
      $display("testbench: %0d task words sent over %0d capacity writes",
               tasks_sent, cap_writes);
      $display("testbench: capacities zero, one, mid, 16 and past depth, long result hold");
      if (error_count == 0 && pending_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
